// ----- rtl/mpps_pkg.sv -----
// shared types, command codes and the note increment rom for the phasor synth
// no dependencies
`default_nettype none

package mpps_pkg;

  // command kinds passed from the front part to the voice engine
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [1:0] MIDI_MSG_LEN    = 2'd3;

  localparam int SAMPLE_W = 34;
  localparam int PHASE_W  = 32;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
  } cmd_t;

  function automatic logic [31:0] inc_rom(input logic [3:0] idx);
    logic [31:0] word;
    case (idx)
      4'd0:    word = 32'd594573364;
      4'd1:    word = 32'd629928536;
      4'd2:    word = 32'd667386036;
      4'd3:    word = 32'd707070875;
      4'd4:    word = 32'd749115497;
      4'd5:    word = 32'd793660223;
      4'd6:    word = 32'd840853716;
      4'd7:    word = 32'd890853479;
      4'd8:    word = 32'd943826384;
      4'd9:    word = 32'd999949221;
      4'd10:   word = 32'd1059409296;
      4'd11:   word = 32'd1122405051;
      default: word = 32'd0;
    endcase
    return word;
  endfunction

  // k = note + 4; octave = k / 12 via multiply by 171 / 2048 (exact for k < 492)
  function automatic logic [31:0] pitch_increment(input logic [6:0] note);
    logic [7:0]  k;
    logic [15:0] prod;
    logic [3:0]  oct;
    logic [7:0]  rem;
    logic [3:0]  shift;
    k     = {1'b0, note} + 8'd4;
    prod  = {8'd0, k} * 16'd171;
    oct   = prod[14:11];
    rem   = k - ({4'd0, oct} * 8'd12);
    shift = 4'd10 - oct;
    return inc_rom(rem[3:0]) >> shift;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mpps_front.sv -----
// input side: accepts stream items, keeps note on, note off and ticks
// and queues them as commands; uses mpps_pkg
`default_nettype none

module mpps_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               in_mode,
  input  wire  [7:0]        in_status,
  input  wire  [6:0]        in_note,
  input  wire  [6:0]        in_velocity,
  input  wire  [1:0]        in_count,
  output logic              cmd_valid,
  input  wire               cmd_ready,
  output mpps_pkg::cmd_t    cmd
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  mpps_pkg::cmd_t     queue [DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [PW:0]        count;

  logic               take;
  logic               is_on;
  logic               is_off;
  logic               push;
  logic               pop;
  mpps_pkg::cmd_t     new_cmd;

  assign in_ready = (count != (PW+1)'(DEPTH));
  assign take     = in_valid && in_ready;

  always_comb begin
    is_on  = (in_status == mpps_pkg::STATUS_NOTE_ON) && (in_velocity != 7'd0);
    is_off = ((in_status == mpps_pkg::STATUS_NOTE_ON) && (in_velocity == 7'd0)) ||
             (in_status == mpps_pkg::STATUS_NOTE_OFF);
    new_cmd.note = in_note;
    if (in_mode) begin
      new_cmd.kind = mpps_pkg::CMD_TICK;
    end else if (is_on) begin
      new_cmd.kind = mpps_pkg::CMD_NOTE_ON;
    end else begin
      new_cmd.kind = mpps_pkg::CMD_NOTE_OFF;
    end
    // anything else is dropped on the floor
    push = take && (in_mode || ((in_count == mpps_pkg::MIDI_MSG_LEN) && (is_on || is_off)));
  end

  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mpps_back.sv -----
// voice engine: runs queued commands over the voice memories, one voice
// per cycle, and holds the finished sample in an output register; uses mpps_pkg
`default_nettype none

module mpps_back #(
  parameter int VOICE_COUNT = 64
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cmd_valid,
  output logic                           cmd_ready,
  input  mpps_pkg::cmd_t                 cmd,
  input  wire                            waveform,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [mpps_pkg::SAMPLE_W-1:0]  out_sample
);

  localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int SUM_W = (28 + VW + 1 > 34) ? (28 + VW + 1) : 34;
  localparam logic [VW-1:0] LAST_VOICE = VW'(VOICE_COUNT - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_OFF  = 3'd2;
  localparam logic [2:0] ST_TICK = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  // voice and note memories
  logic [31:0]    phase_mem [VOICE_COUNT];
  logic [31:0]    inc_mem   [VOICE_COUNT];
  logic [VW-1:0]  map_mem   [128];
  logic [31:0]    phase_q;
  logic [31:0]    inc_q;
  logic [VW-1:0]  map_q;
  logic           map_vq;

  logic [VOICE_COUNT-1:0] active;
  logic [VOICE_COUNT-1:0] pvalid;
  logic [127:0]           map_valid;

  logic [2:0]            state;
  logic [6:0]            note;
  logic [VW-1:0]         idx;
  logic                  issue_done;
  logic                  rd_vld;
  logic [VW-1:0]         rd_idx;
  logic signed [SUM_W-1:0] acc;
  logic                  sq;

  logic                  issue;
  logic [31:0]           p;
  logic signed [SUM_W-1:0] part;
  logic signed [SUM_W-1:0] acc_next;
  logic                  hit;
  logic [VW-1:0]         pick;
  logic [VW-1:0]         off_voice;
  logic                  inc_we;
  logic                  phase_we;
  logic [31:0]           phase_wdata;
  logic                  ovf;
  logic [mpps_pkg::SAMPLE_W-1:0] saw;
  logic [mpps_pkg::SAMPLE_W-1:0] result;
  logic                  emit;

  assign cmd_ready = (state == ST_IDLE);
  assign issue     = (state == ST_TICK) && !issue_done;

  always_comb begin
    p           = pvalid[rd_idx] ? phase_q : 32'd0;
    part        = SUM_W'($signed(p) >>> 4);
    acc_next    = acc + part;
    phase_wdata = p + inc_q;
    phase_we    = rd_vld && active[rd_idx];
    hit         = !active[idx];
    pick        = hit ? idx : '0;
    inc_we      = (state == ST_SCAN) && (hit || (idx == LAST_VOICE));
    off_voice   = map_vq ? map_q : '0;
    ovf         = !((&acc[SUM_W-1:33]) || (~|acc[SUM_W-1:33]));
    if (ovf) begin
      saw = acc[SUM_W-1] ? {1'b1, {(mpps_pkg::SAMPLE_W-1){1'b0}}}
                         : {1'b0, {(mpps_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      saw = acc[mpps_pkg::SAMPLE_W-1:0];
    end
    result = waveform ? {2'b00, sq, 31'd0} : saw;
    emit   = (state == ST_EMIT) && (!out_valid || out_ready);
  end

  // memory ports, read data registered
  always_ff @(posedge clk) begin
    phase_q <= phase_mem[idx];
    inc_q   <= inc_mem[idx];
    if (phase_we) begin
      phase_mem[rd_idx] <= phase_wdata;
    end
    if (inc_we) begin
      inc_mem[pick] <= mpps_pkg::pitch_increment(note);
    end
  end

  always_ff @(posedge clk) begin
    map_q  <= map_mem[cmd.note];
    map_vq <= map_valid[cmd.note];
    if (inc_we) begin
      map_mem[note] <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= '0;
      pvalid     <= '0;
      map_valid  <= '0;
      rd_vld     <= 1'b0;
      issue_done <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      rd_idx     <= '0;
      note       <= '0;
      acc        <= '0;
      sq         <= 1'b0;
    end else begin
      rd_vld <= issue;
      rd_idx <= idx;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (phase_we) begin
        pvalid[rd_idx] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            note       <= cmd.note;
            idx        <= '0;
            issue_done <= 1'b0;
            acc        <= '0;
            sq         <= 1'b0;
            case (cmd.kind)
              mpps_pkg::CMD_NOTE_ON:  state <= ST_SCAN;
              mpps_pkg::CMD_NOTE_OFF: state <= ST_OFF;
              mpps_pkg::CMD_TICK:     state <= ST_TICK;
              default:                state <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          // first free voice, or steal voice 0 when all are busy
          if (inc_we) begin
            active[pick]    <= 1'b1;
            map_valid[note] <= 1'b1;
            state           <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_OFF: begin
          active[off_voice] <= 1'b0;
          map_valid[note]   <= 1'b0;
          state             <= ST_IDLE;
        end
        ST_TICK: begin
          if (issue) begin
            if (idx == LAST_VOICE) begin
              issue_done <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end
          if (phase_we) begin
            acc <= acc_next;
            sq  <= sq | p[31];
          end
          if (rd_vld && (rd_idx == LAST_VOICE)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/midi_polyphonic_phasor_synth.sv -----
// polyphonic phasor synth driven by midi note events and sample ticks
// top level: waveform register on the apb port, front queue and voice engine
// uses mpps_pkg, mpps_front, mpps_back
//
// s_axis carries one item per handshake: tuser = 1 marks a sample tick, else
// tdata holds a midi message. note on (0x90, velocity > 0) and note off (0x80,
// or 0x90 with velocity 0) of length 3 act on the voices; other items are
// taken and dropped. every tick gives one item on m_axis: the mixed sample,
// 34-bit two's complement with 32 fractional bits (sawtooth sum or square).
// a four-entry command queue sits between the input and the voice engine.
// the engine walks the voice memories one voice per cycle: a tick reads every
// voice and sums the active ones, a note on scans for the first free voice, a
// note off clears its voice. a new command is taken only once the last is done.
// the result sits in an output register; while m_axis_tready is low the engine
// holds the next result and the queue keeps taking items until it is full.
// reset clears all voices (increments, phases), the note map and waveform
// at once through per-entry valid bits; no clearing pass is needed.
// waveform (address 0, bit 0) may only be written while the block is idle.
`default_nettype none

module midi_polyphonic_phasor_synth #(
  parameter int VOICE_COUNT = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // status_byte[7:0], note_number[14:8], velocity[21:15], byte_count[23:22]
  input  wire         s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // sample[33:0], zeros above
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [0:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [0:0] ADDR_WAVEFORM = 1'b0;

  logic                           waveform;
  logic                           cmd_valid;
  logic                           cmd_ready;
  mpps_pkg::cmd_t                 cmd;
  logic [mpps_pkg::SAMPLE_W-1:0]  sample;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_WAVEFORM) ? {31'd0, waveform} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_WAVEFORM)) begin
      waveform <= pwdata[0];
    end
  end

  mpps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_mode     (s_axis_tuser),
    .in_status   (s_axis_tdata[7:0]),
    .in_note     (s_axis_tdata[14:8]),
    .in_velocity (s_axis_tdata[21:15]),
    .in_count    (s_axis_tdata[23:22]),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  mpps_back #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .waveform   (waveform),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (sample)
  );

  assign m_axis_tdata = {6'd0, sample};

endmodule

`default_nettype wire
